// ===== sv/cpsm_pkg.sv =====
// cpsm_pkg: shared types and constants for the class pattern substring matcher
// no dependencies; used by every module of the block and by its checker

package cpsm_pkg;

	// one byte of the input string
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} char_item_t;

	// one result per byte
	typedef struct packed {
		logic found;
		logic string_end;
	} result_item_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_PATTERN_LOW  = 2'd0,
		REG_PATTERN_HIGH = 2'd1,
		REG_PATTERN_LEN  = 2'd2
	} cfg_reg_t;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int LEN_W       = 5;
	localparam int PATTERN_CAP = 16;
	localparam int QUEUE_DEPTH = 2;

	// pattern symbol classes and character bounds
	localparam logic [7:0] SYM_DIGIT  = 8'h44; // 'D'
	localparam logic [7:0] SYM_ALPHA  = 8'h41; // 'A'
	localparam logic [7:0] SYM_ANY    = 8'h3F; // '?'
	localparam logic [7:0] CH_ZERO    = 8'h30; // '0'
	localparam logic [7:0] CH_NINE    = 8'h39; // '9'
	localparam logic [7:0] CH_UP_A    = 8'h41; // 'A'
	localparam logic [7:0] CH_UP_Z    = 8'h5A; // 'Z'
	localparam logic [7:0] CH_LOW_A   = 8'h61; // 'a'
	localparam logic [7:0] CH_LOW_Z   = 8'h7A; // 'z'
	localparam logic [7:0] CASE_SHIFT = 8'h20;

endpackage

// ===== sv/class_pattern_substring_matcher_top.sv =====
// class_pattern_substring_matcher_top: top level of the class pattern substring matcher
// depends on cpsm_pkg, cpsm_front, cpsm_queue and cpsm_back
//
// Usage:
//   char channel: one string byte per transaction (char_code, last_char), taken
//   when char_valid is high and char_stall is low. Strings must not be empty.
//   result channel: one result per byte (found, string_end), delivered when
//   result_valid is high and result_stall is low. On a byte with string_end
//   set, found is the verdict for the whole string; the match state then
//   clears for the next string.
//   cfg channel: cfg_ready is always high; index 0 writes pattern symbols 0-7,
//   index 1 symbols 8-15, index 2 the pattern length (zero matches always,
//   values above MAX_PATTERN act as MAX_PATTERN). Other indexes are ignored.
//   A taken byte is written into the queue, then popped into the result register.
//   Throughput: one byte per cycle, set by the shift-and update in the back
//   end; a two-entry queue plus the result register sit between the sides,
//   so char_stall rises only once the queue is full while the receiver
//   holds result_stall.
//   Reset clears the pattern registers, the queue and the match state; no
//   result is pending after reset.

module class_pattern_substring_matcher_top #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                char_valid,
	output logic                                char_stall,
	input  cpsm_pkg::char_item_t                char_data,
	output logic                                result_valid,
	input  logic                                result_stall,
	output cpsm_pkg::result_item_t              result_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cpsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [cpsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int QW = MAX_PATTERN + 1;

	logic [cpsm_pkg::CFG_DATA_W-1:0] pattern_low_q;
	logic [cpsm_pkg::CFG_DATA_W-1:0] pattern_high_q;
	logic [cpsm_pkg::LEN_W-1:0]      pattern_len_q;
	logic [cpsm_pkg::LEN_W-1:0]      eff_len;

	logic          push;
	logic [QW-1:0] push_data;
	logic          queue_full;
	logic          pop;
	logic          q_not_empty;
	logic [QW-1:0] q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			pattern_len_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cpsm_pkg::REG_PATTERN_LOW:  pattern_low_q  <= cfg_data;
				cpsm_pkg::REG_PATTERN_HIGH: pattern_high_q <= cfg_data;
				cpsm_pkg::REG_PATTERN_LEN:  pattern_len_q  <= cfg_data[cpsm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign eff_len = (pattern_len_q > cpsm_pkg::LEN_W'(MAX_PATTERN)) ?
	                 cpsm_pkg::LEN_W'(MAX_PATTERN) : pattern_len_q;

	cpsm_front #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_front (
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data),
		.pattern    ({pattern_high_q, pattern_low_q}),
		.eff_len    (eff_len),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	cpsm_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	cpsm_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_head       (q_head),
		.pop          (pop),
		.eff_len      (eff_len),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

// ===== sv/cpsm_front.sv =====
// cpsm_front: accepts bytes and classifies each one against every pattern symbol
// depends on cpsm_pkg; feeds the per-symbol hit mask into cpsm_queue

module cpsm_front #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                                  char_valid,
	output logic                                  char_stall,
	input  cpsm_pkg::char_item_t                  char_data,
	input  logic [2*cpsm_pkg::CFG_DATA_W-1:0]     pattern,
	input  logic [cpsm_pkg::LEN_W-1:0]            eff_len,
	input  logic                                  queue_full,
	output logic                                  push,
	output logic [MAX_PATTERN:0]                  push_data
);

	logic [MAX_PATTERN-1:0] mask;

	function automatic logic sym_match(input logic [7:0] s, input logic [7:0] c);
		logic hit;
		begin
			priority if (s == cpsm_pkg::SYM_DIGIT) begin
				hit = (c >= cpsm_pkg::CH_ZERO) && (c <= cpsm_pkg::CH_NINE);
			end else if (s == cpsm_pkg::SYM_ALPHA) begin
				hit = ((c >= cpsm_pkg::CH_UP_A) && (c <= cpsm_pkg::CH_UP_Z)) ||
				      ((c >= cpsm_pkg::CH_LOW_A) && (c <= cpsm_pkg::CH_LOW_Z));
			end else if (s == cpsm_pkg::SYM_ANY) begin
				hit = 1'b1;
			end else if ((s >= cpsm_pkg::CH_LOW_A) && (s <= cpsm_pkg::CH_LOW_Z)) begin
				// lowercase symbol takes either case
				hit = (c == s) || (c == (s - cpsm_pkg::CASE_SHIFT));
			end else begin
				hit = (c == s);
			end
			return hit;
		end
	endfunction

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			mask[i] = sym_match(pattern[8*i +: 8], char_data.char_code) &&
			          (cpsm_pkg::LEN_W'(i) < eff_len);
		end
	end

	assign char_stall = queue_full;
	assign push       = char_valid && !queue_full;
	assign push_data  = {mask, char_data.last_char};

endmodule

// ===== sv/cpsm_queue.sv =====
// cpsm_queue: short queue that decouples classification from the match update
// depends on cpsm_pkg for its depth

module cpsm_queue #(
	parameter int WIDTH = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	localparam int DEPTH = cpsm_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/cpsm_back.sv =====
// cpsm_back: shift-and update of the partial match vector and the result register
// depends on cpsm_pkg; pops classified bytes from cpsm_queue

module cpsm_back #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_not_empty,
	input  logic [MAX_PATTERN:0]        q_head,
	output logic                        pop,
	input  logic [cpsm_pkg::LEN_W-1:0]  eff_len,
	output logic                        result_valid,
	input  logic                        result_stall,
	output cpsm_pkg::result_item_t      result_data
);

	logic [MAX_PATTERN-1:0] partial_q;
	logic                   found_q;
	logic                   result_valid_q;
	cpsm_pkg::result_item_t result_q;

	logic [MAX_PATTERN-1:0] mask;
	logic                   last;
	logic [MAX_PATTERN-1:0] vec_next;
	logic [MAX_PATTERN-1:0] top_sel;
	logic                   empty_pat;
	logic                   found_next;

	assign mask      = q_head[MAX_PATTERN:1];
	assign last      = q_head[0];
	assign empty_pat = (eff_len == '0);
	assign pop       = q_not_empty && (!result_valid_q || !result_stall);

	// mask is already cut to the pattern length in the front
	assign vec_next = {partial_q[MAX_PATTERN-2:0], 1'b1} & mask;

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			top_sel[i] = (cpsm_pkg::LEN_W'(i + 1) == eff_len);
		end
	end

	assign found_next = found_q || empty_pat || (|(vec_next & top_sel));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q      <= '0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				result_valid_q <= 1'b1;
				// string boundary clears the match state
				partial_q      <= (last || empty_pat) ? '0 : vec_next;
				found_q        <= last ? 1'b0 : found_next;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.found      <= found_next;
			result_q.string_end <= last;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

// ===== sv/cpsm_checker.sv =====
// cpsm_checker: port-level assertions for class_pattern_substring_matcher_top
// depends on cpsm_pkg; attached to the top level by the bind at the end

module cpsm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             char_valid,
	input logic                             char_stall,
	input logic                             result_valid,
	input logic                             result_stall,
	input cpsm_pkg::result_item_t           result_data,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic [cpsm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [cpsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic       char_acc;
	logic       res_acc;
	logic [2:0] pending_q;
	logic       len_zero_q;

	assign char_acc = char_valid && !char_stall;
	assign res_acc  = result_valid && !result_stall;

	// transactions taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(char_acc) - 3'(res_acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_zero_q <= 1'b1;
		end else if (cfg_valid && cfg_ready &&
		             cfg_index == cpsm_pkg::REG_PATTERN_LEN) begin
			len_zero_q <= (cfg_data[cpsm_pkg::LEN_W-1:0] == '0);
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 3'd0)
		else $error("result with no byte outstanding");

	a_bounded_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more bytes in flight than the buffering allows");

	a_empty_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && len_zero_q |-> result_data.found)
		else $error("empty pattern did not report found");

endmodule

bind class_pattern_substring_matcher_top cpsm_checker u_cpsm_checker (.*);

// ===== test/tb.sv =====
// tb: self-checking bench for class_pattern_substring_matcher_top
// depends on cpsm_pkg and the matcher RTL; drives strings and pattern writes,
// predicts found/string_end per byte and compares every result transaction

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PAT       = 16;
	localparam int RUN_LIMIT     = 200000;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES        = 12;
	localparam int PHASE_BYTES   = 55;
	localparam int MAX_REPORTS   = 200;
	// index with no register behind it, writes must be ignored
	localparam logic [cpsm_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		bit                               is_write;
		logic [cpsm_pkg::CFG_INDEX_W-1:0] idx;
		logic [cpsm_pkg::CFG_DATA_W-1:0]  val;
		logic [7:0]                       ch;
		bit                               last;
		bit                               known;
		bit                               found;
	} step_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             char_valid = 1'b0;
	logic                             char_stall;
	cpsm_pkg::char_item_t             char_data = '0;
	logic                             result_valid;
	logic                             result_stall = 1'b0;
	cpsm_pkg::result_item_t           result_data;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [cpsm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [cpsm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// typed expectation riding along with the byte being offered
	bit drv_known = 1'b0;
	bit drv_found = 1'b0;

	// predictor copy of the registers and the match state
	logic [cpsm_pkg::CFG_DATA_W-1:0] pat_low = '0;
	logic [cpsm_pkg::CFG_DATA_W-1:0] pat_high = '0;
	logic [cpsm_pkg::LEN_W-1:0]      pat_len = '0;
	logic [15:0]                     match_vec = '0;
	logic                            found_q = 1'b0;

	cpsm_pkg::result_item_t pending_results[$];
	int                     mismatch_cnt = 0;
	int                     cycle_cnt = 0;

	// idling knobs, percent per cycle
	int send_idle = 0;
	int recv_stall = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// pattern of the current phase, used to plant matches
	logic [7:0] cur_syms [16];
	int         cur_eff = 0;
	int         sent_bytes = 0;

	class_pattern_substring_matcher_top #(.MAX_PATTERN(MAX_PAT)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_data    (char_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] pattern_sym(int i);
		if (i < 8)
			return pat_low[8*i +: 8];
		return pat_high[8*(i-8) +: 8];
	endfunction

	function automatic bit sym_hit(logic [7:0] s, logic [7:0] c);
		if (s == cpsm_pkg::SYM_DIGIT)
			return c >= cpsm_pkg::CH_ZERO && c <= cpsm_pkg::CH_NINE;
		if (s == cpsm_pkg::SYM_ALPHA)
			return (c >= cpsm_pkg::CH_UP_A && c <= cpsm_pkg::CH_UP_Z) ||
				(c >= cpsm_pkg::CH_LOW_A && c <= cpsm_pkg::CH_LOW_Z);
		if (s == cpsm_pkg::SYM_ANY)
			return 1'b1;
		if (s >= cpsm_pkg::CH_LOW_A && s <= cpsm_pkg::CH_LOW_Z)
			return c == s ||
				({1'b0, c} + {1'b0, cpsm_pkg::CASE_SHIFT}) == {1'b0, s};
		return c == s;
	endfunction

	// shift-and update for one byte, returns the result it produces
	function automatic cpsm_pkg::result_item_t advance_match(cpsm_pkg::char_item_t it);
		int                     n;
		int                     i;
		logic [15:0]            hits;
		cpsm_pkg::result_item_t r;
		n = (pat_len > MAX_PAT) ? MAX_PAT : pat_len;
		if (n == 0) begin
			match_vec = '0;
			found_q = 1'b1;
		end else begin
			hits = '0;
			for (i = 0; i < n; i++)
				if (sym_hit(pattern_sym(i), it.char_code))
					hits[i] = 1'b1;
			match_vec = {match_vec[14:0], 1'b1} & hits;
			if (match_vec[n-1])
				found_q = 1'b1;
		end
		r.found = found_q;
		r.string_end = it.last_char;
		if (it.last_char) begin
			match_vec = '0;
			found_q = 1'b0;
		end
		return r;
	endfunction

	task automatic report_field(string what, logic want, logic got);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("%0t: %s expected %0b actual %0b", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > RUN_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin : monitor
		cpsm_pkg::result_item_t want;
		cpsm_pkg::result_item_t got;
		if (result_valid && !result_stall) begin
			got = result_data;
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("%0t: unexpected result expected none actual found=%0b end=%0b",
						$time, got.found, got.string_end);
			end else begin
				want = pending_results.pop_front();
				if (got.found !== want.found)
					report_field("found", want.found, got.found);
				if (got.string_end !== want.string_end)
					report_field("string_end", want.string_end, got.string_end);
			end
		end
		if (arst_n && char_valid && !char_stall) begin
			want = advance_match(char_data);
			if (drv_known)
				want.found = drv_found;
			pending_results.push_back(want);
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				cpsm_pkg::REG_PATTERN_LOW: pat_low = cfg_data;
				cpsm_pkg::REG_PATTERN_HIGH: pat_high = cfg_data;
				cpsm_pkg::REG_PATTERN_LEN: pat_len = cfg_data[cpsm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// result side: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	// all tasks below start and end at a falling edge
	task automatic put_char(logic [7:0] ch, bit last, bit known, bit fnd);
		cpsm_pkg::char_item_t it;
		it.char_code = ch;
		it.last_char = last;
		while ($urandom_range(99) < send_idle) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_data <= it;
		drv_known <= known;
		drv_found <= fnd;
		do @(posedge clk); while (char_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		char_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [cpsm_pkg::CFG_INDEX_W-1:0] idx,
			logic [cpsm_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic step_row_t write_row(logic [cpsm_pkg::CFG_INDEX_W-1:0] idx,
			logic [cpsm_pkg::CFG_DATA_W-1:0] val);
		step_row_t r;
		r = '{default: 0};
		r.is_write = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic step_row_t byte_row(logic [7:0] ch, bit last, bit known, bit fnd);
		step_row_t r;
		r = '{default: 0};
		r.ch = ch;
		r.last = last;
		r.known = known;
		r.found = fnd;
		return r;
	endfunction

	function automatic logic [7:0] rand_symbol();
		case ($urandom_range(5))
			0: return cpsm_pkg::SYM_DIGIT;
			1: return cpsm_pkg::SYM_ALPHA;
			2: return cpsm_pkg::SYM_ANY;
			3: return cpsm_pkg::CH_LOW_A + 8'($urandom_range(25));
			4: return cpsm_pkg::CH_UP_A + 8'($urandom_range(25));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// a byte that the given symbol accepts
	function automatic logic [7:0] hit_byte(logic [7:0] s);
		if (s == cpsm_pkg::SYM_DIGIT)
			return cpsm_pkg::CH_ZERO + 8'($urandom_range(9));
		if (s == cpsm_pkg::SYM_ALPHA)
			return ($urandom_range(1) ? cpsm_pkg::CH_UP_A : cpsm_pkg::CH_LOW_A) +
				8'($urandom_range(25));
		if (s == cpsm_pkg::SYM_ANY)
			return 8'($urandom_range(255));
		if (s >= cpsm_pkg::CH_LOW_A && s <= cpsm_pkg::CH_LOW_Z)
			return $urandom_range(1) ? s : s - cpsm_pkg::CASE_SHIFT;
		return s;
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(3))
			0: return 8'($urandom_range(255));
			1: return cpsm_pkg::CH_ZERO + 8'($urandom_range(9));
			2: return ($urandom_range(1) ? cpsm_pkg::CH_UP_A : cpsm_pkg::CH_LOW_A) +
				8'($urandom_range(25));
			default: return hit_byte(cur_syms[$urandom_range(15)]);
		endcase
	endfunction

	// one whole string, mostly with the pattern planted somewhere inside
	task automatic send_string();
		logic [7:0] text[$];
		int         pre;
		int         post;
		int         i;
		pre = $urandom_range(3);
		post = $urandom_range(3);
		if ($urandom_range(19) == 0)
			post += $urandom_range(10, 25);
		for (i = 0; i < pre; i++)
			text.push_back(rand_byte());
		if ($urandom_range(99) < 75) begin
			for (i = 0; i < cur_eff; i++)
				text.push_back(hit_byte(cur_syms[i]));
			if (cur_eff > 0 && $urandom_range(9) == 0)
				text[pre + $urandom_range(cur_eff - 1)] = 8'($urandom_range(255));
		end
		for (i = 0; i < post; i++)
			text.push_back(rand_byte());
		if (text.size() == 0)
			text.push_back(rand_byte());
		for (i = 0; i < text.size(); i++) begin
			put_char(text[i], i == text.size() - 1, 1'b0, 1'b0);
			sent_bytes++;
		end
	endtask

	initial begin : stimulus
		step_row_t                       dir_rows[$];
		int                              ph;
		int                              i;
		int                              len;
		bit                              paused;
		logic [cpsm_pkg::CFG_DATA_W-1:0] low_w;
		logic [cpsm_pkg::CFG_DATA_W-1:0] high_w;
		logic [cpsm_pkg::CFG_DATA_W-1:0] len_w;

		// empty pattern after reset: every byte reports found
		dir_rows.push_back(byte_row(8'h00, 1'b0, 1'b1, 1'b1));
		dir_rows.push_back(byte_row(8'hFF, 1'b1, 1'b1, 1'b1));
		// pattern k D ? A # : each symbol class once
		dir_rows.push_back(write_row(cpsm_pkg::REG_PATTERN_LOW,
			{24'h0, 8'h23, cpsm_pkg::SYM_ALPHA, cpsm_pkg::SYM_ANY,
			 cpsm_pkg::SYM_DIGIT, 8'h6B}));
		dir_rows.push_back(write_row(REG_UNUSED, '1));
		dir_rows.push_back(write_row(cpsm_pkg::REG_PATTERN_LEN, 64'd5));
		dir_rows.push_back(byte_row(8'h4B, 1'b0, 1'b1, 1'b0)); // 'K' against 'k'
		dir_rows.push_back(byte_row(8'h37, 1'b0, 1'b1, 1'b0));
		dir_rows.push_back(byte_row(8'hFF, 1'b0, 1'b1, 1'b0));
		dir_rows.push_back(byte_row(8'h7A, 1'b0, 1'b1, 1'b0));
		dir_rows.push_back(byte_row(8'h23, 1'b1, 1'b1, 1'b1));
		dir_rows.push_back(byte_row(8'h6B, 1'b0, 1'b0, 1'b0));
		dir_rows.push_back(byte_row(8'h35, 1'b0, 1'b0, 1'b0));
		dir_rows.push_back(byte_row(8'h2E, 1'b1, 1'b0, 1'b0));
		// sixteen wildcards, length written as all ones so it clamps to the cap
		dir_rows.push_back(write_row(cpsm_pkg::REG_PATTERN_LOW, {8{cpsm_pkg::SYM_ANY}}));
		dir_rows.push_back(write_row(cpsm_pkg::REG_PATTERN_HIGH, {8{cpsm_pkg::SYM_ANY}}));
		dir_rows.push_back(write_row(cpsm_pkg::REG_PATTERN_LEN, '1));
		for (i = 0; i < 16; i++)
			dir_rows.push_back(byte_row(8'(i * 17), i == 15, 1'b1, i == 15));

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_write) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end else begin
				put_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].known,
					dir_rows[i].found);
			end
		end

		paused = 1'b0;
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 82; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 82; end
				default: begin send_idle = 21; recv_stall = 21; end
			endcase
			for (i = 0; i < 16; i++)
				cur_syms[i] = rand_symbol();
			for (i = 0; i < 8; i++) begin
				low_w[8*i +: 8] = cur_syms[i];
				high_w[8*i +: 8] = cur_syms[i+8];
			end
			case ($urandom_range(9))
				0: len = 0;
				1: len = MAX_PAT;
				2: len = $urandom_range(MAX_PAT + 1, 31);
				default: len = $urandom_range(1, 6);
			endcase
			cur_eff = (len > MAX_PAT) ? MAX_PAT : len;
			len_w = {$urandom, $urandom};
			len_w[cpsm_pkg::LEN_W-1:0] = cpsm_pkg::LEN_W'(len);
			write_reg(cpsm_pkg::REG_PATTERN_LOW, low_w);
			write_reg(cpsm_pkg::REG_PATTERN_HIGH, high_w);
			write_reg(cpsm_pkg::REG_PATTERN_LEN, len_w);
			if (ph == 4)
				hold_reqs++;
			while (sent_bytes < (ph + 1) * PHASE_BYTES) begin
				if (ph == 6 && !paused && sent_bytes >= ph * PHASE_BYTES + PHASE_BYTES / 2) begin
					// sender waits for the pipe to run dry before going on
					settle();
					paused = 1'b1;
				end
				send_string();
			end
			// leave a string open so the next pattern lands mid-string
			if ($urandom_range(1))
				for (i = $urandom_range(1, 3); i > 0; i--)
					put_char(rand_byte(), 1'b0, 1'b0, 1'b0);
		end

		settle();
		if (mismatch_cnt == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/cpsm_pkg.sv
sv/cpsm_front.sv
sv/cpsm_queue.sv
sv/cpsm_back.sv
sv/class_pattern_substring_matcher_top.sv
sv/cpsm_checker.sv
test/tb.sv
